/* rtl/core/brnm_pkg.sv */
// Package for the banked ROM / nibble RAM mapper: beat types, codes, sizes.
// No dependencies; used by every module of the block except brnm_ram.
`timescale 1ns / 1ps

package brnm_pkg;

  localparam int RamDepth    = 512;
  localparam int RamAw       = $clog2(RamDepth);
  localparam int NibW        = 4;
  localparam int BankW       = 4;
  localparam int BankOffW    = 14;
  localparam int RomAw       = BankW + BankOffW;
  localparam int CountW      = 5;
  localparam int QueueDepth  = 2;
  localparam int QPtrW       = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW       = $clog2(QueueDepth + 1);

  localparam logic [CountW-1:0] BankCountReset = CountW'(16);
  localparam logic [BankW-1:0]  BankReset      = BankW'(1);
  localparam logic [NibW-1:0]   EnableKey      = 4'hA;

  localparam logic OpRead  = 1'b0;
  localparam logic OpWrite = 1'b1;

  localparam logic [1:0] KindRom   = 2'd0;
  localparam logic [1:0] KindRam   = 2'd1;
  localparam logic [1:0] KindWrite = 2'd2;

  typedef enum logic [1:0] {
    RAM_NONE,
    RAM_READ,
    RAM_OFF,
    RAM_WRITE
  } ram_op_e;

  typedef struct packed {
    logic        op;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]       result_kind;
    logic [RomAw-1:0] rom_address;
    logic [7:0]       read_data;
  } out_beat_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [RomAw-1:0] rom_address;
    ram_op_e          ram_op;
    logic [RamAw-1:0] ram_index;
    logic [NibW-1:0]  nibble;
  } cmd_t;

endpackage

/* rtl/core/brnm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module brnm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/brnm_front.sv */
// Front end: holds bank count, selected bank and RAM enable; decodes each bus
// access into a back-end command. Depends on brnm_pkg.
`timescale 1ns / 1ps

module brnm_front import brnm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  input  logic              take_i,
  input  in_beat_t          beat_i,
  output cmd_t              cmd_o
);

  logic [CountW-1:0] bank_count_q, bank_count_d;
  logic [BankW-1:0]  bank_q, bank_d;
  logic              ram_en_q, ram_en_d;
  logic [CountW-1:0] count_m1;
  logic [BankW-1:0]  bank_mask;
  logic [BankW-1:0]  new_bank;
  logic              low_area;
  logic              ram_area;

  assign low_area  = (beat_i.address[15:14] == 2'b00);
  assign ram_area  = beat_i.address[15];
  assign count_m1  = bank_count_q - CountW'(1);
  assign bank_mask = count_m1[BankW-1:0];
  assign new_bank  = (beat_i.write_data[NibW-1:0] == '0) ? BankReset
                                                         : beat_i.write_data[BankW-1:0];

  always_comb begin
    cmd_o             = '0;
    cmd_o.ram_op      = RAM_NONE;
    cmd_o.ram_index   = beat_i.address[RamAw-1:0];
    cmd_o.nibble      = beat_i.write_data[NibW-1:0];
    bank_d            = bank_q;
    ram_en_d          = ram_en_q;
    bank_count_d      = cfg_we_i ? cfg_wdata_i : bank_count_q;
    if (beat_i.op == OpRead) begin
      if (ram_area) begin
        cmd_o.kind   = KindRam;
        cmd_o.ram_op = ram_en_q ? RAM_READ : RAM_OFF;
      end else begin
        cmd_o.kind        = KindRom;
        cmd_o.rom_address = {(low_area ? BankW'(0) : (bank_q & bank_mask)),
                             beat_i.address[BankOffW-1:0]};
      end
    end else begin
      cmd_o.kind = KindWrite;
      if (low_area && take_i) begin
        if (beat_i.address[8]) begin
          bank_d = new_bank;
        end else begin
          ram_en_d = (beat_i.write_data[NibW-1:0] == EnableKey);
        end
      end
      if (ram_area && ram_en_q) begin
        cmd_o.ram_op = RAM_WRITE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_count_q <= BankCountReset;
      bank_q       <= BankReset;
      ram_en_q     <= 1'b0;
    end else begin
      bank_count_q <= bank_count_d;
      bank_q       <= bank_d;
      ram_en_q     <= ram_en_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bank_q != '0)
    else $error("selected bank is zero");

endmodule

/* rtl/core/brnm_queue.sv */
// Short command queue between front and back end.
// Depends on brnm_pkg.
`timescale 1ns / 1ps

module brnm_queue import brnm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output cmd_t cmd_o
);

  cmd_t             slot_q [QueueDepth];
  logic [QPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  function automatic logic [QPtrW-1:0] next_ptr(input logic [QPtrW-1:0] p);
    next_ptr = (p == QPtrW'(QueueDepth - 1)) ? '0 : p + QPtrW'(1);
  endfunction

  assign full_o  = (cnt_q == QCntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? next_ptr(wr_q) : wr_q;
    rd_d  = do_pop ? next_ptr(rd_q) : rd_q;
    cnt_d = cnt_q + QCntW'(do_push) - QCntW'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QueueDepth))
    else $error("queue count overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_q == rd_q))
    else $error("empty queue with pointers apart");

endmodule

/* rtl/core/brnm_back.sv */
// Back end: performs the nibble RAM access and holds the result beat.
// Depends on brnm_pkg and brnm_ram.
`timescale 1ns / 1ps

module brnm_back import brnm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  logic             valid_q, valid_d;
  logic [1:0]       kind_q;
  logic [RomAw-1:0] rom_q;
  ram_op_e          op_q;
  logic             advance;
  logic [NibW-1:0]  rdata;

  assign advance = !valid_q || !out_stall_i;
  assign pop_o   = cmd_valid_i && advance;
  assign valid_d = advance ? cmd_valid_i : valid_q;

  brnm_ram #(
    .Width (NibW),
    .Depth (RamDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (pop_o && (cmd_i.ram_op == RAM_WRITE)),
    .waddr_i (cmd_i.ram_index),
    .wdata_i (cmd_i.nibble),
    .re_i    (pop_o && (cmd_i.ram_op == RAM_READ)),
    .raddr_i (cmd_i.ram_index),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q <= cmd_i.kind;
      rom_q  <= cmd_i.rom_address;
      op_q   <= cmd_i.ram_op;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_comb begin
    out_beat_o.result_kind = kind_q;
    out_beat_o.rom_address = rom_q;
    case (op_q)
      RAM_READ: out_beat_o.read_data = {4'hF, rdata};
      RAM_OFF:  out_beat_o.read_data = 8'hFF;
      default:  out_beat_o.read_data = 8'h00;
    endcase
  end

  assign out_valid_o = valid_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && kind_q != KindRom) |-> (out_beat_o.rom_address == '0))
    else $error("rom address on a non-ROM beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && kind_q == KindRam) |-> (out_beat_o.read_data[7:4] == 4'hF))
    else $error("RAM read without upper bits set");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && out_stall_i) |=> valid_q)
    else $error("result dropped under stall");

endmodule

/* rtl/core/banked_rom_nibble_ram_mapper_top.sv */
// Top level of the banked ROM / nibble RAM mapper.
// Depends on brnm_pkg, brnm_front, brnm_queue, brnm_back, brnm_ram.
//
//   channel | handshake                 | beat
//   --------+---------------------------+-------------------------------
//   in      | in_valid_i / in_stall_o   | in_beat_i  (op, address, data)
//   out     | out_valid_o / out_stall_i | out_beat_o (kind, rom, data)
//   cfg     | cfg_we_i                  | cfg_wdata_i (bank count)
//
// One beat per cycle sustained while out_stall_i is low; each accepted beat is registered in the
// queue, then in the back-end result register. Each beat makes at most one nibble RAM access.
// Control writes take effect for the very next beat.
// A two-entry queue decouples input from output; in_stall_o rises when full.
// Reset clears bank count to 16, bank to 1, RAM enable off; RAM is not cleared.
`timescale 1ns / 1ps

module banked_rom_nibble_ram_mapper_top import brnm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_beat_t          in_beat_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_beat_t         out_beat_o
);

  cmd_t front_cmd;
  cmd_t queue_cmd;
  logic take;
  logic q_full;
  logic q_valid;
  logic q_pop;

  assign in_stall_o = q_full;
  assign take       = in_valid_i && !q_full;

  brnm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .take_i      (take),
    .beat_i      (in_beat_i),
    .cmd_o       (front_cmd)
  );

  brnm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (take),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .cmd_o   (queue_cmd)
  );

  brnm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (queue_cmd),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule

/* dv/banked_rom_nibble_ram_mapper_top_test.sv */
// Testbench for banked_rom_nibble_ram_mapper_top: directed bus accesses, then random ones
// over several bank-count settings. Results are checked against fixed rows or an in-bench mapper model.
// Depends on brnm_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module banked_rom_nibble_ram_mapper_top_test;
  import brnm_pkg::*;

  localparam int HoldCycles  = 60;
  localparam int PhaseAccess = 120;

  typedef struct {
    in_beat_t  beat;
    bit        fixed;
    out_beat_t want;
  } access_row_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [CountW-1:0] cfg_wdata_i = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  in_beat_t          in_beat_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  out_beat_t         out_beat_o;

  // mapper state as predicted
  logic [CountW-1:0] bank_count = BankCountReset;
  logic [BankW-1:0]  rom_bank   = BankReset;
  logic              ram_on     = 1'b0;
  logic [NibW-1:0]   nibbles [RamDepth];
  bit                nib_valid [RamDepth];
  logic [RamAw-1:0]  written_idx [$];

  out_beat_t   pending_results [$];
  access_row_t directed_rows [$];
  int          mismatches = 0;
  bit          quiet      = 1'b0;
  bit          hold_ask   = 1'b0;

  banked_rom_nibble_ram_mapper_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_beat_i  (in_beat_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_beat_o (out_beat_o)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    #200000;
    $display("simulation failed");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    $display("%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic out_beat_t map_access(input in_beat_t b);
    out_beat_t        r;
    logic [BankW-1:0] mask;
    logic [RamAw-1:0] idx;
    r    = '0;
    idx  = b.address[RamAw-1:0];
    mask = BankW'(bank_count - CountW'(1));
    if (b.op == OpRead) begin
      if (b.address[15:14] == 2'b00) begin
        r.result_kind = KindRom;
        r.rom_address = RomAw'(b.address);
      end else if (!b.address[15]) begin
        r.result_kind = KindRom;
        r.rom_address = {rom_bank & mask, b.address[BankOffW-1:0]};
      end else begin
        r.result_kind = KindRam;
        r.read_data   = ram_on ? {4'hF, nibbles[idx]} : 8'hFF;
      end
    end else begin
      r.result_kind = KindWrite;
      if (b.address[15:14] == 2'b00) begin
        if (!b.address[8]) begin
          ram_on = (b.write_data[NibW-1:0] == EnableKey);
        end else begin
          rom_bank = (b.write_data[NibW-1:0] == '0) ? BankW'(1) : b.write_data[NibW-1:0];
        end
      end else if (b.address[15] && ram_on) begin
        nibbles[idx] = b.write_data[NibW-1:0];
        if (!nib_valid[idx]) begin
          nib_valid[idx] = 1'b1;
          written_idx.push_back(idx);
        end
      end
    end
    return r;
  endfunction

  function automatic in_beat_t random_access();
    in_beat_t b;
    int       pick;
    b.op         = OpRead;
    b.address    = 16'($urandom);
    b.write_data = 8'($urandom);
    pick         = $urandom_range(99);
    if (pick < 22) begin
      b.address[15] = 1'b0;
    end else if (pick < 34) begin
      b.op = OpWrite;
      b.address[15:14] = 2'b00;
      if (!b.address[8] && $urandom_range(3) != 0) b.write_data[NibW-1:0] = EnableKey;
    end else if (pick < 42) begin
      b.op = OpWrite;
      b.address[15:14] = 2'b01;
    end else if (pick < 70) begin
      b.op = OpWrite;
      b.address[15] = 1'b1;
    end else begin
      b.address[15] = 1'b1;
      // enabled reads only touch entries already stored
      if (ram_on) begin
        if (written_idx.size() == 0) begin
          b.address[15] = 1'b0;
        end else begin
          b.address[RamAw-1:0] = written_idx[$urandom_range(written_idx.size() - 1)];
        end
      end
    end
    return b;
  endfunction

  task automatic drive_access(input in_beat_t b, input bit fixed, input out_beat_t want);
    out_beat_t got;
    while (!quiet && $urandom_range(99) < 33) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    got = map_access(b);
    pending_results.push_back(fixed ? want : got);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic apply_bank_count(input logic [CountW-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    bank_count = v;
    cfg_we_i   <= 1'b0;
  endtask

  task automatic add_row(input logic op, input logic [15:0] addr, input logic [7:0] data,
                         input bit fixed, input logic [1:0] kind,
                         input logic [RomAw-1:0] rom, input logic [7:0] rdata);
    access_row_t r;
    r.beat = '{op: op, address: addr, write_data: data};
    r.fixed = fixed;
    r.want = '{result_kind: kind, rom_address: rom, read_data: rdata};
    directed_rows.push_back(r);
  endtask

  // receiver: random stall, or one long hold-off when asked
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_ask) begin
        hold_ask = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end
      out_stall_i <= !quiet && ($urandom_range(99) < 33);
    end
  end

  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result beat with nothing pending: %h", out_beat_o));
      end else begin
        want = pending_results.pop_front();
        if (out_beat_o.result_kind !== want.result_kind)
          flag_mismatch($sformatf("result_kind got %0d want %0d",
                                  out_beat_o.result_kind, want.result_kind));
        if (out_beat_o.rom_address !== want.rom_address)
          flag_mismatch($sformatf("rom_address got %h want %h",
                                  out_beat_o.rom_address, want.rom_address));
        if (out_beat_o.read_data !== want.read_data)
          flag_mismatch($sformatf("read_data got %h want %h",
                                  out_beat_o.read_data, want.read_data));
      end
    end
  end

  initial begin
    logic [CountW-1:0] counts [9] = '{5'd1, 5'd2, 5'd8, 5'd0, 5'd31, 5'd3, 5'd17, 5'd16, 5'd4};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(OpRead,  16'h0000, 8'h00, 1, KindRom,   18'h00000, 8'h00);
    add_row(OpRead,  16'h3FFF, 8'hFF, 1, KindRom,   18'h03FFF, 8'h00);
    add_row(OpRead,  16'h4000, 8'h00, 1, KindRom,   18'h04000, 8'h00);
    add_row(OpRead,  16'h7FFF, 8'h00, 1, KindRom,   18'h07FFF, 8'h00);
    add_row(OpRead,  16'h8000, 8'h00, 1, KindRam,   18'h00000, 8'hFF);
    add_row(OpRead,  16'hFFFF, 8'h00, 1, KindRam,   18'h00000, 8'hFF);
    add_row(OpWrite, 16'hFFFF, 8'h05, 1, KindWrite, 18'h00000, 8'h00);
    add_row(OpWrite, 16'h0000, 8'h0A, 1, KindWrite, 18'h00000, 8'h00);
    add_row(OpWrite, 16'h8000, 8'hFF, 0, KindRom,   18'h00000, 8'h00);
    add_row(OpWrite, 16'h81FF, 8'h00, 0, KindRom,   18'h00000, 8'h00);
    add_row(OpRead,  16'hFE00, 8'h00, 0, KindRom,   18'h00000, 8'h00);
    add_row(OpRead,  16'hA1FF, 8'h00, 0, KindRom,   18'h00000, 8'h00);
    add_row(OpWrite, 16'h0100, 8'h00, 0, KindRom,   18'h00000, 8'h00);
    add_row(OpRead,  16'h5555, 8'h00, 0, KindRom,   18'h00000, 8'h00);
    add_row(OpWrite, 16'h3FFF, 8'hFF, 0, KindRom,   18'h00000, 8'h00);
    add_row(OpRead,  16'h7FFF, 8'h00, 0, KindRom,   18'h00000, 8'h00);
    add_row(OpWrite, 16'h4000, 8'hAA, 1, KindWrite, 18'h00000, 8'h00);
    add_row(OpWrite, 16'h7FFF, 8'h0A, 1, KindWrite, 18'h00000, 8'h00);
    add_row(OpWrite, 16'h00FF, 8'h1A, 0, KindRom,   18'h00000, 8'h00);
    add_row(OpWrite, 16'h3EFF, 8'h0B, 0, KindRom,   18'h00000, 8'h00);
    add_row(OpRead,  16'h8000, 8'h00, 1, KindRam,   18'h00000, 8'hFF);
    add_row(OpWrite, 16'h8000, 8'h03, 0, KindRom,   18'h00000, 8'h00);
    add_row(OpWrite, 16'h2000, 8'hFA, 0, KindRom,   18'h00000, 8'h00);
    add_row(OpRead,  16'h8000, 8'h00, 0, KindRom,   18'h00000, 8'h00);

    foreach (directed_rows[i])
      drive_access(directed_rows[i].beat, directed_rows[i].fixed, directed_rows[i].want);
    settle();

    foreach (counts[ph]) begin
      apply_bank_count(counts[ph]);
      quiet = (ph == 3);
      for (int n = 0; n < PhaseAccess; n++) begin
        // long output hold-off while beats keep coming
        if (ph == 1 && n == 40) hold_ask = 1'b1;
        drive_access(random_access(), 1'b0, '0);
      end
      settle();
    end

    repeat (6) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/brnm_pkg.sv
rtl/core/brnm_ram.sv
rtl/core/brnm_front.sv
rtl/core/brnm_queue.sv
rtl/core/brnm_back.sv
rtl/core/banked_rom_nibble_ram_mapper_top.sv
dv/banked_rom_nibble_ram_mapper_top_test.sv
